// File: rtl/core/ndg_pkg.sv
// package for the nearest-one distance grid block
// constants, register indexes and small helpers; no dependencies
`default_nettype none

package ndg_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;

    localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int POS_W  = $clog2(MAX_CELLS + 1);
    localparam int CFG_W  = 4;
    localparam int DIST_W = 4;
    localparam int IDX_W  = 1;

    localparam logic [DIST_W-1:0] DIST_SAT   = 4'd15;
    localparam logic [CFG_W-1:0]  SIZE_RESET = 4'd8;

    typedef enum logic [IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_index_t;

    // saturating increment of a distance
    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        begin
            r = (v >= DIST_SAT) ? DIST_SAT : v + DIST_W'(1);
            return r;
        end
    endfunction

    function automatic logic [DIST_W-1:0] dist_min(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        logic [DIST_W-1:0] r;
        begin
            r = (a < b) ? a : b;
            return r;
        end
    endfunction

    // zero counts as one, values above the maximum count as the maximum
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int hi);
        logic [CFG_W-1:0] r;
        begin
            if (v == '0)
                r = CFG_W'(1);
            else if (int'(v) > hi)
                r = CFG_W'(hi);
            else
                r = v;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/nearest_one_distance_grid.sv
// top level of the nearest-one (manhattan) distance transform over a binary grid
// uses ndg_pkg for sizes, register indexes and distance helpers
// out_valid for the first result rises once the request completing a grid has been
//   taken and the forward and backward passes have run; in_stall is high until emit ends
// throughput: one cell per cycle in each of load, forward pass, backward pass and
//   emit, with emit held while out_stall is high; set by the sequencer stepping through
//   the grid once per phase, with one distance memory write per cell in each pass
// reset: config registers return to 8 x 8, load position to 0, no result pending;
//   grid and distance memories are not cleared
`default_nettype none

module nearest_one_distance_grid (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_we,
    input  wire logic [ndg_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [ndg_pkg::CFG_W-1:0]    cfg_data,
    // input request channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         cell_is_one,
    // result request channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ndg_pkg::DIST_W-1:0]        distance,
    output logic                              no_source,
    output logic                              last_cell
);

    localparam int AW = ndg_pkg::ADDR_W;
    localparam int PW = ndg_pkg::POS_W;
    localparam int CW = ndg_pkg::CFG_W;
    localparam int DW = ndg_pkg::DIST_W;

    // load: take cells; fwd/bwd: relaxation passes; emit: stream results
    typedef enum logic [1:0] {
        S_LOAD,
        S_FWD,
        S_BWD,
        S_EMIT
    } state_t;

    // registers
    state_t          state_reg,  state_next;
    logic [CW-1:0]   rows_reg,   rows_next;
    logic [CW-1:0]   cols_reg,   cols_next;
    logic [PW-1:0]   pos_reg,    pos_next;
    logic            any_reg,    any_next;
    logic [AW-1:0]   k_reg,      k_next;
    logic [CW-1:0]   r_reg,      r_next;
    logic [CW-1:0]   c_reg,      c_next;
    logic [DW-1:0]   prev_reg,   prev_next;
    logic            out_valid_reg, out_valid_next;
    logic [DW-1:0]   distance_reg,  distance_next;
    logic            no_source_reg, no_source_next;
    logic            last_cell_reg, last_cell_next;

    // memories with registered read data
    logic            cell_mem [ndg_pkg::MAX_CELLS];
    logic [DW-1:0]   dist_mem [ndg_pkg::MAX_CELLS];
    logic            cell_rd_reg;
    logic [DW-1:0]   dist_a_reg;
    logic [DW-1:0]   dist_b_reg;

    // memory control
    logic            cell_we;
    logic [AW-1:0]   cell_waddr;
    logic            dist_we;
    logic [DW-1:0]   dist_wd;
    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;

    // grid geometry
    logic [CW-1:0]   rows_c;
    logic [CW-1:0]   cols_c;
    logic [CW-1:0]   rows_m1;
    logic [CW-1:0]   cols_m1;
    logic [AW-1:0]   cols_a;
    logic [PW-1:0]   total;
    logic [AW-1:0]   last_idx;

    logic            in_acc;
    logic            slot_free;
    logic [DW-1:0]   up_c;
    logic [DW-1:0]   left_c;
    logic [DW-1:0]   down_c;
    logic [DW-1:0]   right_c;
    logic [DW-1:0]   fwd_val;
    logic [DW-1:0]   bwd_val;

    assign rows_c   = ndg_pkg::clamp_size(rows_reg, ndg_pkg::MAX_ROWS);
    assign cols_c   = ndg_pkg::clamp_size(cols_reg, ndg_pkg::MAX_COLS);
    assign rows_m1  = rows_c - CW'(1);
    assign cols_m1  = cols_c - CW'(1);
    assign cols_a   = AW'(cols_c);
    assign total    = PW'(rows_c) * PW'(cols_c);
    assign last_idx = AW'(total - PW'(1));

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign no_source = no_source_reg;
    assign last_cell = last_cell_reg;

    // forward pass: own cell, from above and from the left
    assign up_c    = (r_reg != '0) ? ndg_pkg::sat_inc(dist_a_reg) : ndg_pkg::DIST_SAT;
    assign left_c  = (c_reg != '0) ? ndg_pkg::sat_inc(prev_reg) : ndg_pkg::DIST_SAT;
    assign fwd_val = cell_rd_reg ? '0 : ndg_pkg::dist_min(up_c, left_c);

    // backward pass: forward result, from below and from the right
    assign down_c  = (r_reg != rows_m1) ? ndg_pkg::sat_inc(dist_b_reg) : ndg_pkg::DIST_SAT;
    assign right_c = (c_reg != cols_m1) ? ndg_pkg::sat_inc(prev_reg) : ndg_pkg::DIST_SAT;
    assign bwd_val = ndg_pkg::dist_min(dist_a_reg, ndg_pkg::dist_min(down_c, right_c));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        pos_next       = pos_reg;
        any_next       = any_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && out_stall;
        distance_next  = distance_reg;
        no_source_next = no_source_reg;
        last_cell_next = last_cell_reg;
        cell_we        = 1'b0;
        cell_waddr     = AW'(pos_reg);
        dist_we        = 1'b0;
        dist_wd        = fwd_val;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    cell_we  = 1'b1;
                    any_next = ((pos_reg == '0) ? 1'b0 : any_reg) | cell_is_one;
                    if (pos_reg == total - PW'(1))
                    begin
                        // grid complete, start the forward pass at the first cell
                        pos_next   = '0;
                        state_next = S_FWD;
                        k_next     = '0;
                        r_next     = '0;
                        c_next     = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end
            S_FWD:
            begin
                dist_we   = 1'b1;
                dist_wd   = fwd_val;
                prev_next = fwd_val;
                if (k_reg == last_idx)
                begin
                    state_next = S_BWD;
                    k_next     = last_idx;
                    r_next     = rows_m1;
                    c_next     = cols_m1;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                    if (c_reg == cols_m1)
                    begin
                        c_next = '0;
                        r_next = r_reg + CW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end
            S_BWD:
            begin
                dist_we   = 1'b1;
                dist_wd   = bwd_val;
                prev_next = bwd_val;
                if (k_reg == '0)
                begin
                    state_next = S_EMIT;
                    k_next     = '0;
                end
                else
                begin
                    k_next = k_reg - AW'(1);
                    if (c_reg == '0)
                    begin
                        c_next = cols_m1;
                        r_next = r_reg - CW'(1);
                    end
                    else
                    begin
                        c_next = c_reg - CW'(1);
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = any_reg ? dist_a_reg : ndg_pkg::DIST_SAT;
                    no_source_next = !any_reg;
                    last_cell_next = (k_reg == last_idx);
                    if (k_reg == last_idx)
                        state_next = S_LOAD;
                    else
                        k_next = k_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // a register write drops any partly loaded grid
        if (cfg_we)
        begin
            case (cfg_index)
                ndg_pkg::CFG_ROWS:
                begin
                    rows_next = cfg_data;
                    pos_next  = '0;
                end
                ndg_pkg::CFG_COLS:
                begin
                    cols_next = cfg_data;
                    pos_next  = '0;
                end
                default:
                begin
                    pos_next = pos_next;
                end
            endcase
        end
    end

    // read addresses follow the next cell, so read data lines up with k_reg
    assign addr_a = (state_next == S_FWD) ? (k_next - cols_a) : k_next;
    assign addr_b = k_next + cols_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            rows_reg      <= ndg_pkg::SIZE_RESET;
            cols_reg      <= ndg_pkg::SIZE_RESET;
            pos_reg       <= '0;
            any_reg       <= 1'b0;
            k_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            pos_reg       <= pos_next;
            any_reg       <= any_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        distance_reg  <= distance_next;
        no_source_reg <= no_source_next;
        last_cell_reg <= last_cell_next;
    end

    // grid memory, write-first so a one-cell grid reads its fresh cell
    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_is_one;
        if (cell_we && (cell_waddr == k_next))
            cell_rd_reg <= cell_is_one;
        else
            cell_rd_reg <= cell_mem[k_next];
    end

    // distance memory, one write and two reads; write-first covers one-column grids
    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[k_reg] <= dist_wd;
        if (dist_we && (k_reg == addr_a))
            dist_a_reg <= dist_wd;
        else
            dist_a_reg <= dist_mem[addr_a];
        if (dist_we && (k_reg == addr_b))
            dist_b_reg <= dist_wd;
        else
            dist_b_reg <= dist_mem[addr_b];
    end

    // checks
    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (pos_reg < total))
        else $error("load position beyond grid size");

    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWD || state_reg == S_BWD) |-> (PW'(k_reg) < total))
        else $error("relaxation pass beyond grid size");

    a_no_source_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_source) |-> (distance == ndg_pkg::DIST_SAT))
        else $error("no-source result without saturated distance");

    a_emit_ends_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && k_reg == last_idx)
            |=> (out_valid && last_cell && state_reg == S_LOAD))
        else $error("final result not flagged as last cell");

endmodule

`default_nettype wire

// File: sim/nearest_one_distance_grid_tb.sv
// testbench for nearest_one_distance_grid: random and directed binary grids
// checked against a distance-map predictor; depends on ndg_pkg and the rtl top
`timescale 1ns / 1ps

module nearest_one_distance_grid_tb;

    localparam int LATENCY    = 2 * ndg_pkg::MAX_CELLS + 8;  // both passes plus slack
    localparam int QUIET_MAX  = 4000;               // cycles with no transfer
    localparam int HOLD_LEN   = 400;                // long receiver hold-off
    localparam int ITEM_GOAL  = 170;

    typedef struct packed {
        logic [ndg_pkg::DIST_W-1:0] hops;
        logic                       none;
        logic                       last;
    } cell_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    ndg_pkg::cfg_index_t        cfg_index = ndg_pkg::CFG_ROWS;
    logic [ndg_pkg::CFG_W-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       cell_is_one = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [ndg_pkg::DIST_W-1:0] distance;
    logic                       no_source;
    logic                       last_cell;

    nearest_one_distance_grid dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_is_one(cell_is_one),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .distance   (distance),
        .no_source  (no_source),
        .last_cell  (last_cell)
    );

    // predictor copy of the block's configuration and grid
    logic [ndg_pkg::CFG_W-1:0]  rows_setting = ndg_pkg::SIZE_RESET;
    logic [ndg_pkg::CFG_W-1:0]  cols_setting = ndg_pkg::SIZE_RESET;
    logic                       grid_cells [ndg_pkg::MAX_CELLS];
    int                         cells_loaded = 0;

    bit                cells_to_send [$];   // requests waiting for the driver
    cell_result_t      pending_results [$]; // distances still to arrive
    int                failures = 0;
    int                idle_pct = 24;
    int                hold_requests = 0;
    bit                req_taken = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // zero counts as one, anything above the maximum counts as the maximum
    function automatic int fit_size(logic [ndg_pkg::CFG_W-1:0] v, int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic int grid_area();
        return fit_size(rows_setting, ndg_pkg::MAX_ROWS)
             * fit_size(cols_setting, ndg_pkg::MAX_COLS);
    endfunction

    // store one cell; when it completes the grid, run both raster passes and
    // queue one expected distance per cell
    task automatic load_cell(bit c);
        int rows;
        int cols;
        int total;
        int k;
        bit any_one;
        logic [ndg_pkg::DIST_W-1:0] dmap [ndg_pkg::MAX_CELLS];
        logic [ndg_pkg::DIST_W-1:0] cand;
        cell_result_t res;
        rows = fit_size(rows_setting, ndg_pkg::MAX_ROWS);
        cols = fit_size(cols_setting, ndg_pkg::MAX_COLS);
        total = rows * cols;
        any_one = 1'b0;
        if (cells_loaded >= total)
            cells_loaded = 0;
        grid_cells[cells_loaded] = c;
        cells_loaded++;
        if (cells_loaded < total)
            return;
        cells_loaded = 0;
        for (k = 0; k < total; k++)
        begin
            dmap[k] = grid_cells[k] ? '0 : ndg_pkg::DIST_SAT;
            if (grid_cells[k])
                any_one = 1'b1;
        end
        // forward pass, neighbors above and to the left
        for (int r = 0; r < rows; r++)
        begin
            for (int cc = 0; cc < cols; cc++)
            begin
                k = r * cols + cc;
                if (r > 0)
                begin
                    cand = (dmap[k-cols] >= ndg_pkg::DIST_SAT) ? ndg_pkg::DIST_SAT
                                                                : dmap[k-cols] + 1'b1;
                    if (cand < dmap[k])
                        dmap[k] = cand;
                end
                if (cc > 0)
                begin
                    cand = (dmap[k-1] >= ndg_pkg::DIST_SAT) ? ndg_pkg::DIST_SAT
                                                             : dmap[k-1] + 1'b1;
                    if (cand < dmap[k])
                        dmap[k] = cand;
                end
            end
        end
        // backward pass, neighbors below and to the right
        for (int r = rows - 1; r >= 0; r--)
        begin
            for (int cc = cols - 1; cc >= 0; cc--)
            begin
                k = r * cols + cc;
                if (r + 1 < rows)
                begin
                    cand = (dmap[k+cols] >= ndg_pkg::DIST_SAT) ? ndg_pkg::DIST_SAT
                                                                : dmap[k+cols] + 1'b1;
                    if (cand < dmap[k])
                        dmap[k] = cand;
                end
                if (cc + 1 < cols)
                begin
                    cand = (dmap[k+1] >= ndg_pkg::DIST_SAT) ? ndg_pkg::DIST_SAT
                                                             : dmap[k+1] + 1'b1;
                    if (cand < dmap[k])
                        dmap[k] = cand;
                end
            end
        end
        for (k = 0; k < total; k++)
        begin
            res.hops = any_one ? dmap[k] : ndg_pkg::DIST_SAT;
            res.none = !any_one;
            res.last = (k + 1 == total);
            pending_results.push_back(res);
        end
    endtask

    // driver: offers the next request unless it idles; holds a stalled one
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid    <= 1'b1;
                cell_is_one <= cells_to_send.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off when one is asked for
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // monitor: predicts on accepted requests, checks accepted results
    always @(posedge clk)
    begin
        cell_result_t exp_res;
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
            load_cell(cell_is_one);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: distance %0d no_source %0b last_cell %0b",
                       distance, no_source, last_cell);
                failures++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (distance !== exp_res.hops)
                begin
                    $error("distance: expected %0d, actual %0d", exp_res.hops, distance);
                    failures++;
                end
                if (no_source !== exp_res.none)
                begin
                    $error("no_source: expected %0b, actual %0b", exp_res.none, no_source);
                    failures++;
                end
                if (last_cell !== exp_res.last)
                begin
                    $error("last_cell: expected %0b, actual %0b", exp_res.last, last_cell);
                    failures++;
                end
            end
        end
    end

    // watchdog on stretches with no transfer on either channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // register write, only ever issued while the block is idle
    task automatic write_reg(ndg_pkg::cfg_index_t idx, logic [ndg_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == ndg_pkg::CFG_ROWS)
            rows_setting = value;
        else
            cols_setting = value;
        cells_loaded = 0;   // any write drops a partial grid
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all requests to go in and all results to come out, then let
    // the block finish any pass it may still be running
    task automatic drain();
        while (cells_to_send.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // queue n cells; density 0 and 100 give empty and full grids,
    // a negative density places a single source at a random spot
    task automatic queue_cells(int n, int density);
        int spot;
        spot = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (density < 0)
                cells_to_send.push_back(i == spot);
            else
                cells_to_send.push_back($urandom_range(0, 99) < density);
        end
    endtask

    function automatic int pick_density();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 100;
            2: return -1;
            default: return $urandom_range(5, 50);
        endcase
    endfunction

    function automatic logic [ndg_pkg::CFG_W-1:0] pick_size(bit allow_big);
        int roll;
        roll = $urandom_range(0, 99);
        if (allow_big && roll < 8)
            return (roll < 4) ? ndg_pkg::CFG_W'(8) : ndg_pkg::CFG_W'($urandom_range(9, 15));
        if (roll < 18)
            return '0;
        return ndg_pkg::CFG_W'($urandom_range(1, 4));
    endfunction

    initial
    begin
        int items;
        int phase;
        int big_grids;
        int grids;
        int area;
        logic [ndg_pkg::CFG_W-1:0] new_rows;
        logic [ndg_pkg::CFG_W-1:0] new_cols;
        items = 0;
        phase = 0;
        big_grids = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single cell with and without a source
        write_reg(ndg_pkg::CFG_ROWS, 4'd1);
        write_reg(ndg_pkg::CFG_COLS, 4'd1);
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b0);
        drain();
        // zero sizes count as one
        write_reg(ndg_pkg::CFG_ROWS, 4'd0);
        write_reg(ndg_pkg::CFG_COLS, 4'd0);
        cells_to_send.push_back(1'b1);
        drain();
        // single row, source at the far end
        write_reg(ndg_pkg::CFG_ROWS, 4'd1);
        write_reg(ndg_pkg::CFG_COLS, 4'd4);
        queue_cells(3, 0);
        cells_to_send.push_back(1'b1);
        drain();
        // grid with no source at all
        write_reg(ndg_pkg::CFG_ROWS, 4'd3);
        write_reg(ndg_pkg::CFG_COLS, 4'd2);
        queue_cells(6, 0);
        drain();
        // every cell a source
        write_reg(ndg_pkg::CFG_ROWS, 4'd2);
        write_reg(ndg_pkg::CFG_COLS, 4'd2);
        queue_cells(4, 100);
        drain();
        // partial grid dropped by a register write, then a fresh grid
        queue_cells(3, 100);
        drain();
        write_reg(ndg_pkg::CFG_COLS, 4'd2);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b0);
        drain();
        items = 24;

        // pressure: oversized rows clamp to the maximum, receiver holds off
        // while the sender keeps pushing the next grid in
        write_reg(ndg_pkg::CFG_ROWS, 4'hF);
        write_reg(ndg_pkg::CFG_COLS, 4'd8);
        hold_requests++;
        queue_cells(ndg_pkg::MAX_CELLS, pick_density());
        queue_cells(16, 30);
        items += ndg_pkg::MAX_CELLS + 16;
        big_grids++;
        drain();

        // random phases of well-formed grids, a few ending in a dropped
        // partial grid
        while (items < ITEM_GOAL)
        begin
            phase++;
            idle_pct = (phase >= 2 && phase <= 4) ? 0 : 24;
            new_rows = pick_size(big_grids < 2);
            new_cols = pick_size(big_grids < 2);
            if ($urandom_range(0, 99) < 20)
                write_reg(ndg_pkg::cfg_index_t'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? new_rows : new_cols);
            else
            begin
                write_reg(ndg_pkg::CFG_ROWS, new_rows);
                write_reg(ndg_pkg::CFG_COLS, new_cols);
            end
            area = grid_area();
            if (area > 16)
                big_grids++;
            grids = (area > 16) ? 1 : $urandom_range(1, 3);
            for (int g = 0; g < grids; g++)
                queue_cells(area, pick_density());
            items += grids * area;
            if (area > 1 && $urandom_range(0, 99) < 15)
            begin
                queue_cells($urandom_range(1, area - 1), 40);
                items++;
            end
            drain();
        end
        idle_pct = 24;

        drain();
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
